// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/irpw_pkg.sv =====
`timescale 1ns / 1ps

package irpw_pkg;

  localparam int BITS_PER_FRAME = 8;
  localparam int BL_W           = $clog2(BITS_PER_FRAME + 1);
  localparam int TICK_W         = 16;
  localparam int CFG_ADDR_W     = 2;

  localparam logic [TICK_W-1:0] LEAD_RST  = 16'd3000;
  localparam logic [TICK_W-1:0] LONG_RST  = 16'd1600;
  localparam logic [TICK_W-1:0] SHORT_RST = 16'd800;

  localparam logic [CFG_ADDR_W-1:0] REG_LEAD  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SHORT = 2'd2;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEAD = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_HIGH = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] code_byte;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } out_item_t;

endpackage

// ===== sv/ir_pulse_width_byte_transmitter_core.sv =====
// IR pulse-width byte transmitter.
// in_*  : valid/ready channel of items. kind=load starts a frame with code_byte
//         (MSB first); kind=tick advances time by one tick.
// out_* : valid/ready channel, exactly one result item per input item, giving
//         the line level, busy flag, end-of-frame flag and load-rejected flag.
// cfg_* : write-only port, cfg_addr 0/1/2 = lead/long/short tick counts; the
//         user writes only while idle (not enforced); zero behaves as one.
// Latency: the result of an item is valid the cycle after it is accepted.
// Throughput: one item per cycle unless out_ready stalls; the frame state is
// updated by decrement/compare logic between state and result registers.
// The output register is the only buffer: in_ready is high when it is empty
// or being drained, so a stalled receiver holds in_ready low after one item.
// Reset (synchronous, rst_n low): idle, line low, no result pending, tick
// registers back to 3000/1600/800.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ir_pulse_width_byte_transmitter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  irpw_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output irpw_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [irpw_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [irpw_pkg::TICK_W-1:0]         cfg_wdata
);

  localparam int BPF = irpw_pkg::BITS_PER_FRAME;
  localparam int BLW = irpw_pkg::BL_W;
  localparam int TW  = irpw_pkg::TICK_W;

  logic [TW-1:0]       lead_r, long_r, short_r;
  logic [1:0]          phase_r, phase_nxt;
  logic [TW-1:0]       ticks_r, ticks_nxt;
  logic [BPF-1:0]      shift_r, shift_nxt;
  logic [BLW-1:0]      bits_r, bits_nxt;
  logic                level_r, level_nxt;
  logic                out_valid_r;
  irpw_pkg::out_item_t out_item_r, out_item_nxt;

  logic                in_acc;
  logic [TW-1:0]       ticks_dec;
  logic [BLW-1:0]      bits_dec;
  logic [BPF+7:0]      code_ext;
  logic [BPF-1:0]      shift_up;

  function automatic logic [TW-1:0] at_least_one(input logic [TW-1:0] v);
    return (v == '0) ? TW'(1) : v;
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign ticks_dec = (ticks_r != '0) ? ticks_r - TW'(1) : ticks_r;
  assign bits_dec  = (bits_r != '0) ? bits_r - BLW'(1) : bits_r;
  assign code_ext  = {{BPF{1'b0}}, in_item.code_byte};
  assign shift_up  = shift_r << 1;

  always_comb begin
    phase_nxt    = phase_r;
    ticks_nxt    = ticks_r;
    shift_nxt    = shift_r;
    bits_nxt     = bits_r;
    level_nxt    = level_r;
    out_item_nxt = '0;
    if (in_item.kind == irpw_pkg::KIND_LOAD) begin
      if (phase_r != irpw_pkg::PH_IDLE) begin
        out_item_nxt.rejected = 1'b1;
      end else begin
        shift_nxt = code_ext[BPF-1:0];
        bits_nxt  = BLW'(BPF);
        phase_nxt = irpw_pkg::PH_LEAD;
        level_nxt = 1'b1;
        ticks_nxt = at_least_one(lead_r);
      end
    end else if (phase_r != irpw_pkg::PH_IDLE) begin
      ticks_nxt = ticks_dec;
      if (ticks_dec == '0) begin
        case (phase_r)
          irpw_pkg::PH_LEAD: begin
            phase_nxt = irpw_pkg::PH_LOW;
            level_nxt = 1'b0;
            ticks_nxt = at_least_one(shift_r[BPF-1] ? long_r : short_r);
          end
          irpw_pkg::PH_LOW: begin
            phase_nxt = irpw_pkg::PH_HIGH;
            level_nxt = 1'b1;
            ticks_nxt = at_least_one(shift_r[BPF-1] ? short_r : long_r);
          end
          default: begin
            shift_nxt = shift_up;
            bits_nxt  = bits_dec;
            if (bits_dec == '0) begin
              phase_nxt = irpw_pkg::PH_IDLE;
              level_nxt = 1'b0;
              out_item_nxt.frame_done = 1'b1;
            end else begin
              phase_nxt = irpw_pkg::PH_LOW;
              level_nxt = 1'b0;
              ticks_nxt = at_least_one(shift_up[BPF-1] ? long_r : short_r);
            end
          end
        endcase
      end
    end
    out_item_nxt.line_level = level_nxt;
    out_item_nxt.busy_res   = (phase_nxt != irpw_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= irpw_pkg::LEAD_RST;
      long_r  <= irpw_pkg::LONG_RST;
      short_r <= irpw_pkg::SHORT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        irpw_pkg::REG_LEAD:  lead_r  <= cfg_wdata;
        irpw_pkg::REG_LONG:  long_r  <= cfg_wdata;
        irpw_pkg::REG_SHORT: short_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= irpw_pkg::PH_IDLE;
      ticks_r     <= '0;
      shift_r     <= '0;
      bits_r      <= '0;
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        ticks_r <= ticks_nxt;
        shift_r <= shift_nxt;
        bits_r  <= bits_nxt;
        level_r <= level_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_item_r <= out_item_nxt;
    end
  end

  `ASSERT_IMPL(a_idle_low, clk, rst_n, phase_r == irpw_pkg::PH_IDLE, !level_r)
  `ASSERT_IMPL(a_ticks_live, clk, rst_n, phase_r != irpw_pkg::PH_IDLE, ticks_r != '0)
  `ASSERT_ALWAYS(a_level_phase, clk, rst_n,
    level_r == (phase_r == irpw_pkg::PH_LEAD || phase_r == irpw_pkg::PH_HIGH))
  `ASSERT_ALWAYS(a_bits_range, clk, rst_n, bits_r <= BLW'(BPF))
  `ASSERT_NEXT(a_reject, clk, rst_n,
    in_acc && in_item.kind == irpw_pkg::KIND_LOAD && phase_r != irpw_pkg::PH_IDLE,
    out_valid_r && out_item_r.rejected && $stable(phase_r) && $stable(ticks_r))

endmodule
